@@ src/msbs_pkg.sv @@
// ----------------------------------------------------------------------------
// msbs_pkg: shared constants and types
// Sizes, stream word layout and the structs passed between the comparator
// cells, the tally stage and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package msbs_pkg;

	localparam int unsigned MaxPattern = 256;
	localparam int unsigned IdxW       = $clog2(MaxPattern);
	localparam int unsigned LenW       = 9;
	localparam int unsigned SweepW     = $clog2(MaxPattern + 1);
	localparam int unsigned PosW       = 32;
	localparam int unsigned CntW       = 32;
	localparam int unsigned ByteW      = 8;

	localparam int unsigned InDataW    = 24;
	localparam int unsigned OutBitsW   = 1 + PosW + CntW;
	localparam int unsigned OutDataW   = ((OutBitsW + 7) / 8) * 8;

	localparam logic [PosW-1:0] PosMax = '1;
	localparam logic [CntW-1:0] CntMax = '1;

	// kind codes on tuser
	localparam logic KindLoad = 1'b0;
	localparam logic KindData = 1'b1;

	typedef struct packed {
		logic             care;
		logic [ByteW-1:0] value;
	} pat_ent_t;

	typedef struct packed {
		logic data_en;   // data byte accepted: shift history, capture hit
		logic sweep_en;  // realignment shift of the pattern row
		logic load_en;   // pattern entry write into the selected cell
	} cell_ctl_t;

	typedef struct packed {
		logic            valid;
		logic            last;
		logic            ok;     // window complete and length usable
		logic [PosW-1:0] start;  // start offset of the window
	} s1_info_t;

	typedef struct packed {
		logic [CntW-1:0] match_count;
		logic [PosW-1:0] first_position;
		logic            found;
	} result_t;

endpackage

`default_nettype wire

@@ src/masked_byte_signature_search_unit.sv @@
// ----------------------------------------------------------------------------
// masked_byte_signature_search_unit: wildcard byte pattern search
// Report path: cell hit and stage-1 registers, then the tally result register.
// Throughput: one load or data transaction per cycle when not stalled,
//   from the comparator row, which scores the full window as a byte enters.
// A length write realigns the pattern row: s_tready is low while it runs.
// Reset clears control, counters and pattern care bits; history is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_signature_search_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// [7:0] pattern_index, [15:8] byte_value, [16] care, rest zero
	input  wire logic [msbs_pkg::InDataW-1:0]    s_tdata,
	// [0] kind
	input  wire logic                            s_tuser,
	input  wire logic                            s_tlast,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// [0] found, [32:1] first_position, [64:33] match_count, rest zero
	output logic [msbs_pkg::OutDataW-1:0]        m_tdata,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [msbs_pkg::LenW-1:0]       cfg_data
);

	localparam int unsigned NP = msbs_pkg::MaxPattern;
	localparam int unsigned IW = msbs_pkg::IdxW;
	localparam int unsigned LW = msbs_pkg::LenW;
	localparam int unsigned SW = msbs_pkg::SweepW;
	localparam int unsigned PW = msbs_pkg::PosW;
	localparam int unsigned BW = msbs_pkg::ByteW;

	// input fields
	logic [IW-1:0] in_idx;
	logic [BW-1:0] in_byte;
	logic          in_care;
	assign in_idx  = s_tdata[IW-1:0];
	assign in_byte = s_tdata[IW+BW-1:IW];
	assign in_care = s_tdata[IW+BW];

	logic [LW-1:0]  len_q;
	logic           sweep_busy_q;
	logic [SW-1:0]  sweep_cnt_q;
	logic           accept;
	logic           data_acc;
	logic           load_acc;
	logic           stall;
	logic           len_ok;

	// raw pattern store
	logic [BW-1:0]  pat_mem_q [NP];
	logic [NP-1:0]  care_q;
	logic [BW-1:0]  rd_byte_q;
	logic           rd_care_q;
	logic           rd_win_q;
	logic [LW:0]    sweep_sum;
	logic [IW-1:0]  raw_idx;
	logic           sweep_rd;

	assign s_tready  = !sweep_busy_q && !stall;
	assign cfg_ready = !sweep_busy_q;
	assign accept    = s_tvalid && s_tready;
	assign data_acc  = accept && (s_tuser == msbs_pkg::KindData);
	assign load_acc  = accept && (s_tuser == msbs_pkg::KindLoad);
	assign len_ok    = (len_q != '0) && (len_q <= LW'(NP));

	// length register and realignment sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= '0;
			sweep_busy_q <= 1'b0;
			sweep_cnt_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			len_q        <= cfg_data;
			sweep_busy_q <= 1'b1;
			sweep_cnt_q  <= '0;
		end else if (sweep_busy_q) begin
			sweep_cnt_q <= sweep_cnt_q + 1'b1;
			if (sweep_cnt_q == SW'(NP)) begin
				sweep_busy_q <= 1'b0;
			end
		end
	end

	// step t of the sweep fills cell NP-1-t with raw entry t+len-NP
	assign sweep_sum = (LW+1)'(sweep_cnt_q[IW-1:0]) + (LW+1)'(len_q);
	assign raw_idx   = sweep_sum[IW-1:0];
	assign sweep_rd  = sweep_busy_q && (sweep_cnt_q != SW'(NP));

	always_ff @(posedge clk) begin
		if (load_acc) begin
			pat_mem_q[in_idx] <= in_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_rd) begin
			rd_byte_q <= pat_mem_q[raw_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			care_q    <= '0;
			rd_care_q <= 1'b0;
			rd_win_q  <= 1'b0;
		end else begin
			if (load_acc) begin
				care_q[in_idx] <= in_care;
			end
			if (sweep_rd) begin
				rd_care_q <= care_q[raw_idx];
				rd_win_q  <= sweep_sum >= (LW+1)'(NP);
			end
		end
	end

	// mid-stream load lands directly in its aligned cell
	logic [LW-1:0]  load_tgt_w;
	logic [IW-1:0]  load_tgt;
	logic           load_in_win;
	assign load_tgt_w  = len_q - LW'(1) - LW'(in_idx);
	assign load_tgt    = load_tgt_w[IW-1:0];
	assign load_in_win = len_ok && (LW'(in_idx) < len_q);

	msbs_pkg::cell_ctl_t ctl;
	msbs_pkg::pat_ent_t  load_ent;
	msbs_pkg::pat_ent_t  sweep_feed;
	assign ctl.data_en   = data_acc;
	assign ctl.sweep_en  = sweep_busy_q && (sweep_cnt_q != '0);
	assign ctl.load_en   = load_acc && load_in_win;
	assign load_ent.care  = in_care;
	assign load_ent.value = in_byte;
	assign sweep_feed.care  = rd_win_q && rd_care_q;
	assign sweep_feed.value = rd_byte_q;

	msbs_pkg::pat_ent_t  pat_w  [NP];
	logic [BW-1:0]       hist_w [NP];
	logic [NP-1:0]       hits;

	genvar k;
	generate
		for (k = 0; k < NP; k++) begin : g_cell
			logic                sel;
			msbs_pkg::pat_ent_t  p_in;
			logic [BW-1:0]       h_in;
			assign sel = (load_tgt == IW'(k));
			if (k == 0) begin : g_head
				assign p_in = sweep_feed;
				assign h_in = in_byte;
			end else begin : g_body
				assign p_in = pat_w[k-1];
				assign h_in = hist_w[k-1];
			end
			msbs_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.sel      (sel),
				.load_ent (load_ent),
				.pat_in   (p_in),
				.pat_out  (pat_w[k]),
				.hist_in  (h_in),
				.hist_out (hist_w[k]),
				.hit      (hits[k])
			);
		end
	endgenerate

	// stream position and window bookkeeping
	logic [PW-1:0]        pos_q;
	logic [PW-1:0]        seen;
	msbs_pkg::s1_info_t   s1_s1;

	assign seen = (pos_q != msbs_pkg::PosMax) ? pos_q + 1'b1 : pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (data_acc) begin
			pos_q <= s_tlast ? '0 : seen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_s1 <= '0;
		end else if (!stall) begin
			s1_s1.valid <= data_acc;
			s1_s1.last  <= s_tlast;
			s1_s1.ok    <= len_ok && (seen >= PW'(len_q));
			s1_s1.start <= seen - PW'(len_q);
		end
	end

	msbs_pkg::result_t res;

	msbs_tally u_tally (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1        (s1_s1),
		.hits      (hits),
		.out_ready (m_tready),
		.stall     (stall),
		.out_valid (m_tvalid),
		.result    (res)
	);

	assign m_tdata = msbs_pkg::OutDataW'(res);

endmodule

`default_nettype wire

@@ src/msbs_cell.sv @@
// ----------------------------------------------------------------------------
// msbs_cell: one comparator cell
// Holds one history byte and one aligned pattern entry; both shift on to the
// next cell. Registers whether the incoming byte satisfies the local entry.
// ----------------------------------------------------------------------------
`default_nettype none

module msbs_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire msbs_pkg::cell_ctl_t          ctl,
	input  wire logic                         sel,
	input  wire msbs_pkg::pat_ent_t           load_ent,
	input  wire msbs_pkg::pat_ent_t           pat_in,
	output msbs_pkg::pat_ent_t                pat_out,
	input  wire logic [msbs_pkg::ByteW-1:0]   hist_in,
	output logic [msbs_pkg::ByteW-1:0]        hist_out,
	output logic                              hit
);

	msbs_pkg::pat_ent_t              pat_q;
	logic [msbs_pkg::ByteW-1:0]      hist_q;
	logic                            hit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
		end else if (ctl.sweep_en) begin
			pat_q <= pat_in;
		end else if (ctl.load_en && sel) begin
			pat_q <= load_ent;
		end
	end

	// history needs no reset: incomplete windows are never scored
	always_ff @(posedge clk) begin
		if (ctl.data_en) begin
			hist_q <= hist_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else if (ctl.data_en) begin
			hit_s1 <= !pat_q.care || (hist_in == pat_q.value);
		end
	end

	assign pat_out  = pat_q;
	assign hist_out = hist_q;
	assign hit      = hit_s1;

endmodule

`default_nettype wire

@@ src/msbs_tally.sv @@
// ----------------------------------------------------------------------------
// msbs_tally: match accounting and result register
// Reduces the cell hits, keeps first offset and saturating count, and
// presents the report on the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module msbs_tally (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire msbs_pkg::s1_info_t                 s1,
	input  wire logic [msbs_pkg::MaxPattern-1:0]    hits,
	input  wire logic                               out_ready,
	output logic                                    stall,
	output logic                                    out_valid,
	output msbs_pkg::result_t                       result
);

	logic                        any_q;
	logic [msbs_pkg::PosW-1:0]   first_q;
	logic [msbs_pkg::CntW-1:0]   count_q;
	logic                        out_valid_q;
	msbs_pkg::result_t           res_q;

	logic                        fire;
	logic                        match;
	logic                        any_n;
	logic [msbs_pkg::PosW-1:0]   first_n;
	logic [msbs_pkg::CntW-1:0]   count_n;

	assign stall = s1.valid && s1.last && out_valid_q && !out_ready;
	assign fire  = s1.valid && !stall;
	assign match = s1.ok && (&hits);

	always_comb begin
		any_n   = any_q || match;
		first_n = (!any_q && match) ? s1.start : first_q;
		count_n = (match && (count_q != msbs_pkg::CntMax)) ? count_q + 1'b1 : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q   <= 1'b0;
			first_q <= '0;
			count_q <= '0;
		end else if (fire) begin
			if (s1.last) begin
				any_q   <= 1'b0;
				first_q <= '0;
				count_q <= '0;
			end else begin
				any_q   <= any_n;
				first_q <= first_n;
				count_q <= count_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && s1.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && s1.last) begin
			res_q.found          <= any_n;
			res_q.first_position <= first_n;
			res_q.match_count    <= count_n;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = res_q;

endmodule

`default_nettype wire

@@ src/msbs_checker.sv @@
// ----------------------------------------------------------------------------
// msbs_checker: port-level checks for the search unit
// Watches the stream and configuration ports; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module msbs_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic                            s_tuser,
	input wire logic                            s_tlast,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [msbs_pkg::OutDataW-1:0]   m_tdata,
	input wire logic                            cfg_valid,
	input wire logic                            cfg_ready
);

	localparam int unsigned PW = msbs_pkg::PosW;
	localparam int unsigned CW = msbs_pkg::CntW;

	// a stalled report holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("report changed while stalled");

	// not found implies zero offset and zero count
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[PW:1] == '0) && (m_tdata[PW+CW:PW+1] == '0))
		else $error("report without match carries offset or count");

	// a length write starts realignment, input and config closed next cycle
	a_cfg_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !s_tready && !cfg_ready)
		else $error("ports open right after length write");

	// a fresh report traces back to a last data transaction on the stream port
	a_report_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |->
			$past(s_tvalid && s_tready && (s_tuser == msbs_pkg::KindData) && s_tlast, 2))
		else $error("report without last data transaction");

endmodule

bind masked_byte_signature_search_unit msbs_checker u_msbs_checker (.*);

`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: masked_byte_signature_search_unit
// Loads wildcard patterns and streams data bytes through the stream port,
// predicts every end-of-stream report (found, first offset, match count) and
// checks it against the output stream. Covers several pattern lengths,
// including zero and lengths above the pattern capacity, plus random
// backpressure, a long output hold-off and a sender pause.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	localparam int unsigned StallLimit = 3000;
	localparam int unsigned DrainGap   = 4;

	typedef struct packed {
		logic                       kind;
		logic [msbs_pkg::IdxW-1:0]  idx;
		logic [msbs_pkg::ByteW-1:0] value;
		logic                       care;
		logic                       last;
	} stim_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [msbs_pkg::InDataW-1:0]  s_tdata   = '0;
	logic                          s_tuser   = 1'b0;
	logic                          s_tlast   = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [msbs_pkg::OutDataW-1:0] m_tdata;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [msbs_pkg::LenW-1:0]     cfg_data  = '0;

	masked_byte_signature_search_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stimulus and expected reports
	stim_t              pending_items[$];
	msbs_pkg::result_t  expected_reports[$];
	stim_t              in_flight;
	int unsigned src_idle_pct   = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned hold_total     = 0;
	int unsigned hold_used      = 0;
	int unsigned fail_count     = 0;
	int unsigned shown_errors   = 0;
	int unsigned items_accepted = 0;
	int unsigned reports_seen   = 0;
	int unsigned length_writes  = 0;
	int unsigned quiet_cycles   = 0;

	// predicted search state
	logic [msbs_pkg::ByteW-1:0] pat_val [msbs_pkg::MaxPattern];
	logic                       pat_care[msbs_pkg::MaxPattern];
	logic [msbs_pkg::ByteW-1:0] hist    [msbs_pkg::MaxPattern];
	int unsigned                hist_head  = 0;
	logic [msbs_pkg::PosW-1:0]  bytes_seen = '0;
	logic [msbs_pkg::CntW-1:0]  hit_count  = '0;
	logic [msbs_pkg::PosW-1:0]  first_hit  = '0;
	logic                       any_hit    = 1'b0;
	logic [msbs_pkg::LenW-1:0]  cur_length = '0;

	// generator-side view of the pattern as it will be when queued items land
	logic [msbs_pkg::ByteW-1:0] plan_val [msbs_pkg::MaxPattern];
	logic                       plan_care[msbs_pkg::MaxPattern];
	int unsigned                plan_eff = 1;

	initial begin
		foreach (pat_val[k]) begin
			pat_val[k]   = '0;
			pat_care[k]  = 1'b0;
			hist[k]      = '0;
			plan_val[k]  = '0;
			plan_care[k] = 1'b0;
		end
	end

	task automatic search_step(input stim_t it);
		int unsigned               j;
		int unsigned               slot;
		int unsigned               pos;
		logic                      hit;
		logic [msbs_pkg::PosW-1:0] seen_now;
		msbs_pkg::result_t         rep;
		if (it.kind == msbs_pkg::KindLoad) begin
			pat_val[it.idx]  = it.value;
			pat_care[it.idx] = it.care;
		end else begin
			slot       = hist_head;
			hist[slot] = it.value;
			hist_head  = (slot + 1) % msbs_pkg::MaxPattern;
			seen_now   = (bytes_seen != msbs_pkg::PosMax) ? bytes_seen + 1'b1 : bytes_seen;
			if (cur_length != 0 && cur_length <= msbs_pkg::MaxPattern
					&& seen_now >= cur_length) begin
				hit = 1'b1;
				for (j = 0; j < cur_length; j++) begin
					pos = (slot + 1 + j + msbs_pkg::MaxPattern - cur_length)
						% msbs_pkg::MaxPattern;
					if (pat_care[j] && hist[pos] != pat_val[j])
						hit = 1'b0;
				end
				if (hit) begin
					if (!any_hit) begin
						first_hit = seen_now - cur_length;
						any_hit   = 1'b1;
					end
					if (hit_count != msbs_pkg::CntMax)
						hit_count = hit_count + 1'b1;
				end
			end
			bytes_seen = seen_now;
			if (it.last) begin
				rep.found          = any_hit;
				rep.first_position = any_hit ? first_hit : '0;
				rep.match_count    = hit_count;
				expected_reports.insert(expected_reports.size(), rep);
				foreach (hist[k])
					hist[k] = '0;
				hist_head  = 0;
				bytes_seen = '0;
				hit_count  = '0;
				first_hit  = '0;
				any_hit    = 1'b0;
			end
		end
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				search_step(in_flight);
				items_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					in_flight = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {7'b0, in_flight.care, in_flight.value, in_flight.idx};
					s_tuser  <= in_flight.kind;
					s_tlast  <= in_flight.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output ready: long hold-offs first, random stalls otherwise
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_used < hold_total) begin
			m_tready <= 1'b0;
			hold_used++;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// report monitor
	always @(posedge clk) begin
		msbs_pkg::result_t got;
		msbs_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[msbs_pkg::OutBitsW-1:0];
			if (expected_reports.size() == 0) begin
				fail_count++;
				if (shown_errors < 10)
					$display("unexpected report: found=%0d first=%0d count=%0d",
						got.found, got.first_position, got.match_count);
				shown_errors++;
			end else begin
				want = expected_reports.pop_front();
				reports_seen++;
				if (got.found !== want.found || got.first_position !== want.first_position
						|| got.match_count !== want.match_count) begin
					fail_count++;
					if (shown_errors < 10)
						$display({"report %0d mismatch: exp found=%0d first=%0d count=%0d,",
							" got found=%0d first=%0d count=%0d"},
							reports_seen, want.found, want.first_position, want.match_count,
							got.found, got.first_position, got.match_count);
					shown_errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= StallLimit) begin
			$display("timeout: no transaction for %0d cycles", StallLimit);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic push_load(input int unsigned idx, input int unsigned value,
			input logic care, input logic last);
		stim_t it;
		it.kind  = msbs_pkg::KindLoad;
		it.idx   = idx[msbs_pkg::IdxW-1:0];
		it.value = value[msbs_pkg::ByteW-1:0];
		it.care  = care;
		it.last  = last;
		plan_val[it.idx]  = it.value;
		plan_care[it.idx] = care;
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic push_data(input int unsigned value, input logic last);
		stim_t       it;
		int unsigned junk_idx;
		junk_idx = $urandom_range(0, 255);
		it.kind  = msbs_pkg::KindData;
		it.idx   = junk_idx[msbs_pkg::IdxW-1:0];
		it.value = value[msbs_pkg::ByteW-1:0];
		it.care  = ($urandom_range(0, 1) == 1);
		it.last  = last;
		pending_items.insert(pending_items.size(), it);
	endtask

	// wait until nothing is queued or expected, then cover the report latency
	task automatic drain();
		while (pending_items.size() != 0 || s_tvalid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (DrainGap) @(posedge clk);
	endtask

	task automatic write_length(input logic [msbs_pkg::LenW-1:0] len);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		cur_length = len;
		length_writes++;
		plan_eff = (len == 0 || len > msbs_pkg::MaxPattern) ? 6 : len;
	endtask

	// mostly data with embedded (sometimes cut short) pattern copies, plus
	// pattern reloads mid-stream and loads flagged last
	task automatic plan_items(input int unsigned n_items, input int unsigned last_pct);
		int unsigned made;
		int unsigned pick;
		int unsigned span;
		int unsigned j;
		int unsigned b;
		made = 0;
		while (made < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				push_load($urandom_range(0, 1) ? $urandom_range(0, plan_eff - 1)
					: $urandom_range(0, 255), $urandom_range(0, 255),
					($urandom_range(0, 1) == 1), $urandom_range(0, 3) == 0);
				made++;
			end else if (pick < 40) begin
				span = (pick < 14) ? $urandom_range(1, plan_eff) : plan_eff;
				for (j = 0; j < span; j++) begin
					b = plan_care[j] ? plan_val[j] : $urandom_range(0, 255);
					push_data(b, (j == span - 1) && ($urandom_range(0, 99) < 30));
					made++;
				end
			end else begin
				b = $urandom_range(0, 1) ? plan_val[$urandom_range(0, plan_eff - 1)]
					: $urandom_range(0, 255);
				push_data(b, $urandom_range(0, 99) < last_pct);
				made++;
			end
		end
	endtask

	// mode: 0 plain, 1 long output hold-off, 2 sender pause halfway
	task automatic run_phase(input logic [msbs_pkg::LenW-1:0] len,
			input int unsigned n_items, input int unsigned last_pct,
			input int unsigned src_pct, input int unsigned sink_pct,
			input int unsigned mode);
		int unsigned j;
		int unsigned seeds;
		drain();
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		write_length(len);
		seeds = (plan_eff < 12) ? plan_eff : 12;
		for (j = 0; j < seeds; j++)
			push_load(j, $urandom_range(0, 255), $urandom_range(0, 9) < 7, 1'b0);
		if (mode == 1)
			hold_total += 400;
		if (mode == 2) begin
			plan_items(n_items / 2, last_pct);
			while (pending_items.size() != 0 || s_tvalid || expected_reports.size() != 0)
				@(posedge clk);
			plan_items(n_items - n_items / 2, last_pct);
		end else begin
			plan_items(n_items, last_pct);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pattern AB ?? CD, back-to-back hits, short stream, extremes
		write_length(9'd3);
		push_load(0, 8'hAB, 1'b1, 1'b0);
		push_load(1, 8'hFF, 1'b0, 1'b0);
		push_load(2, 8'hCD, 1'b1, 1'b0);
		push_load(255, 8'h00, 1'b1, 1'b1);
		push_data(8'hAB, 1'b0);
		push_data(8'h00, 1'b0);
		push_data(8'hCD, 1'b0);
		push_data(8'hAB, 1'b0);
		push_data(8'hFF, 1'b0);
		push_data(8'hCD, 1'b0);
		push_data(8'hAB, 1'b1);
		push_data(8'hAB, 1'b1);
		push_data(8'hFF, 1'b0);
		push_data(8'hAB, 1'b0);
		push_data(8'h00, 1'b0);
		push_data(8'hCD, 1'b1);
		push_data(8'h00, 1'b0);
		push_data(8'hCD, 1'b1);
		drain();
		write_length(9'd0);
		push_data(8'hAB, 1'b0);
		push_data(8'h00, 1'b0);
		push_data(8'hCD, 1'b1);
		drain();
		write_length(9'd511);
		push_data(8'hAB, 1'b0);
		push_data(8'h55, 1'b0);
		push_data(8'hCD, 1'b1);

		run_phase(9'd3,   16, 12,  0,  0, 0);
		run_phase(9'd1,   16, 15, 47,  0, 0);
		run_phase(9'd2,   16, 12,  0, 47, 0);
		run_phase(9'd4,   16, 10, 36, 36, 0);
		run_phase(9'd0,   16, 15, 47,  0, 0);
		run_phase(9'd511, 16, 15,  0, 47, 0);
		run_phase(9'd256, 40,  1, 36, 36, 0);
		run_phase(9'($urandom_range(5, 16)), 16, 10, 0, 0, 0);
		run_phase(9'd1,   40, 60,  0,  0, 1);
		run_phase(9'd8,   40, 10, 47, 47, 2);

		drain();
		repeat (8) @(posedge clk);
		if (expected_reports.size() != 0) begin
			$display("%0d expected reports never arrived", expected_reports.size());
			fail_count += expected_reports.size();
		end
		$display("run: %0d input transactions, %0d reports checked, %0d length writes",
			items_accepted, reports_seen, length_writes);
		$display("lengths 0 to 511 incl. capacity, output hold-off and sender pause; %0d errors",
			fail_count);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
